// File: rtl/core/svpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpc_pkg
// Types, codes and constants shared by the valve stepper controller core.
// ----------------------------------------------------------------------------
package svpc_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_SET    = 3'd3,
        CMD_NUDGE  = 3'd4,
        CMD_HOME   = 3'd5,
        CMD_SWEEP  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        REG_STEP_INTERVAL = 2'd0,
        REG_IDLE_RELEASE  = 2'd1,
        REG_HOME_STEPS    = 2'd2,
        REG_NUDGE_GAIN    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_LOCKED   = 2'd0,
        ST_MOVING   = 2'd1,
        ST_HOMING   = 2'd2,
        ST_SWEEPING = 2'd3
    } status_t;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_REV  = 2'sb11;

    localparam logic [9:0]  STEP_INTERVAL_RST = 10'd12;
    localparam logic [15:0] IDLE_RELEASE_RST  = 16'd250;
    localparam logic [9:0]  HOME_STEPS_RST    = 10'd300;
    localparam logic [4:0]  NUDGE_GAIN_RST    = 5'd5;

    localparam logic [9:0]  TSS_MAX = 10'h3FF;
    localparam logic [15:0] TSF_MAX = 16'hFFFF;

    typedef struct packed {
        logic [9:0]  step_interval;
        logic [15:0] idle_release;
        logic [9:0]  home_steps;
        logic [4:0]  nudge_gain;
    } cfg_t;

    typedef struct packed {
        logic running;
        logic homing;
        logic sweeping;
        logic sweep_up;
        logic energized;
    } flags_t;

    // coil order: a+, a-, b+, b-
    function automatic logic [3:0] coil_row(input logic [1:0] phase);
        logic [3:0] row;
        case (phase)
            2'd0:    row = 4'b1010;
            2'd1:    row = 4'b0110;
            2'd2:    row = 4'b0101;
            default: row = 4'b1001;
        endcase
        return row;
    endfunction

endpackage

// File: rtl/core/svpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpc interfaces
// Command word channel and result word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface svpc_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic signed [9:0] amount;

    modport source (output valid, command, amount, input ready);
    modport sink   (input valid, command, amount, output ready);
endinterface

interface svpc_res_if;
    logic              valid;
    logic              ready;
    logic              coil_a_plus;
    logic              coil_a_minus;
    logic              coil_b_plus;
    logic              coil_b_minus;
    logic [7:0]        position;
    logic [7:0]        target_position;
    logic signed [1:0] spin_direction;
    logic              stepped;
    logic [1:0]        status;

    modport source (output valid, coil_a_plus, coil_a_minus, coil_b_plus, coil_b_minus,
                    position, target_position, spin_direction, stepped, status,
                    input ready);
    modport sink   (input valid, coil_a_plus, coil_a_minus, coil_b_plus, coil_b_minus,
                    position, target_position, spin_direction, stepped, status,
                    output ready);
endinterface

// File: rtl/core/stepper_valve_position_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_valve_position_controller_core
// Full-step valve stepper controller: one command word in, one result word out.
// The result word is registered: valid in the cycle after the command is taken.
// Throughput: 1 word per cycle while res.ready; one result register holds on stall.
// Reset (rst_n, async low): motor state cleared, cfg at defaults; coils not reset.
// ----------------------------------------------------------------------------
module stepper_valve_position_controller_core
    import svpc_pkg::*;
#(
    parameter int MAX_POSITION = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    svpc_cmd_if.sink    cmd,
    svpc_res_if.source  res
);

    localparam int PW = $clog2(MAX_POSITION + 1);

    cfg_t              cfg;
    flags_t            flags_reg, flags_next;
    logic [1:0]        phase_reg, phase_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     tgt_reg, tgt_next;
    logic [9:0]        tss_reg, tss_next;
    logic [15:0]       tsf_reg, tsf_next;
    logic [9:0]        home_left_reg, home_left_next;
    logic signed [1:0] last_dir_reg, last_dir_next;
    logic              stepped;
    status_t           status;

    logic              res_valid_reg;
    logic [3:0]        coils_reg;
    logic [7:0]        position_reg;
    logic [7:0]        target_reg;
    logic signed [1:0] dir_reg;
    logic              stepped_reg;
    status_t           status_reg;
    logic              accept;

    svpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svpc_step #(
        .MAX_POSITION (MAX_POSITION),
        .PW           (PW)
    ) u_step (
        .cfg            (cfg),
        .command        (cmd.command),
        .amount         (cmd.amount),
        .flags          (flags_reg),
        .phase          (phase_reg),
        .pos            (pos_reg),
        .tgt            (tgt_reg),
        .tss            (tss_reg),
        .tsf            (tsf_reg),
        .home_left      (home_left_reg),
        .last_dir       (last_dir_reg),
        .flags_next     (flags_next),
        .phase_next     (phase_next),
        .pos_next       (pos_next),
        .tgt_next       (tgt_next),
        .tss_next       (tss_next),
        .tsf_next       (tsf_next),
        .home_left_next (home_left_next),
        .last_dir_next  (last_dir_next),
        .stepped        (stepped),
        .status         (status)
    );

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '{running: 1'b0, homing: 1'b0, sweeping: 1'b0,
                               sweep_up: 1'b1, energized: 1'b0};
            phase_reg     <= '0;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            tss_reg       <= '0;
            tsf_reg       <= '0;
            home_left_reg <= '0;
            last_dir_reg  <= DIR_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                flags_reg     <= flags_next;
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                tgt_reg       <= tgt_next;
                tss_reg       <= tss_next;
                tsf_reg       <= tsf_next;
                home_left_reg <= home_left_next;
                last_dir_reg  <= last_dir_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coils_reg    <= flags_next.energized ? coil_row(phase_next) : 4'b0000;
            position_reg <= 8'(pos_next);
            target_reg   <= 8'(tgt_next);
            dir_reg      <= last_dir_next;
            stepped_reg  <= stepped;
            status_reg   <= status;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.coil_a_plus     = coils_reg[3];
    assign res.coil_a_minus    = coils_reg[2];
    assign res.coil_b_plus     = coils_reg[1];
    assign res.coil_b_minus    = coils_reg[0];
    assign res.position        = position_reg;
    assign res.target_position = target_reg;
    assign res.spin_direction  = dir_reg;
    assign res.stepped         = stepped_reg;
    assign res.status          = status_reg;

endmodule

// File: rtl/core/svpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module svpc_cfg
    import svpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_STEP_INTERVAL: cfg_next.step_interval = cfg_data[9:0];
                REG_IDLE_RELEASE:  cfg_next.idle_release  = cfg_data;
                REG_HOME_STEPS:    cfg_next.home_steps    = cfg_data[9:0];
                REG_NUDGE_GAIN:    cfg_next.nudge_gain    = cfg_data[4:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_interval <= STEP_INTERVAL_RST;
            cfg_reg.idle_release  <= IDLE_RELEASE_RST;
            cfg_reg.home_steps    <= HOME_STEPS_RST;
            cfg_reg.nudge_gain    <= NUDGE_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/svpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpc_step
// Next-state logic for one command word: tick scheduling, homing, sweep,
// target tracking, clamping and coil release.
// ----------------------------------------------------------------------------
module svpc_step
    import svpc_pkg::*;
#(
    parameter int MAX_POSITION = 255,
    parameter int PW           = 8
)
(
    input  cfg_t              cfg,
    input  logic [2:0]        command,
    input  logic signed [9:0] amount,
    input  flags_t            flags,
    input  logic [1:0]        phase,
    input  logic [PW-1:0]     pos,
    input  logic [PW-1:0]     tgt,
    input  logic [9:0]        tss,
    input  logic [15:0]       tsf,
    input  logic [9:0]        home_left,
    input  logic signed [1:0] last_dir,
    output flags_t            flags_next,
    output logic [1:0]        phase_next,
    output logic [PW-1:0]     pos_next,
    output logic [PW-1:0]     tgt_next,
    output logic [9:0]        tss_next,
    output logic [15:0]       tsf_next,
    output logic [9:0]        home_left_next,
    output logic signed [1:0] last_dir_next,
    output logic              stepped,
    output status_t           status
);

    localparam int SW = ((PW > 15) ? PW : 15) + 2;
    localparam logic [PW-1:0]        POS_MAX   = PW'(MAX_POSITION);
    localparam logic signed [SW-1:0] POS_MAX_S = SW'(MAX_POSITION);
    localparam logic [PW-1:0]        POS_ONE   = PW'(1);

    function automatic logic [PW-1:0] clamp_pos(input logic signed [SW-1:0] v);
        logic [PW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > POS_MAX_S)
            r = POS_MAX;
        else
            r = v[PW-1:0];
        return r;
    endfunction

    logic [9:0]               tss_inc;
    logic [15:0]              tsf_inc;
    logic                     due;
    logic signed [15:0]       nudge_prod;
    logic signed [SW-1:0]     nudge_sum;
    logic signed [SW-1:0]     amount_ext;

    assign tss_inc    = (tss == TSS_MAX) ? tss : tss + 10'd1;
    assign tsf_inc    = (tsf == TSF_MAX) ? tsf : tsf + 16'd1;
    assign due        = tss_inc >= cfg.step_interval;
    assign nudge_prod = 16'(amount) * 16'($signed({1'b0, cfg.nudge_gain}));
    assign amount_ext = SW'(amount);
    assign nudge_sum  = $signed({{(SW-PW){1'b0}}, tgt}) + SW'(nudge_prod);

    always_comb
    begin
        flags_next     = flags;
        phase_next     = phase;
        pos_next       = pos;
        tgt_next       = tgt;
        tss_next       = tss;
        tsf_next       = tsf;
        home_left_next = home_left;
        last_dir_next  = last_dir;
        stepped        = 1'b0;

        case (command)
            CMD_TICK:
            begin
                tss_next = tss_inc;
                tsf_next = tsf_inc;
                if (flags.homing)
                begin
                    if (due)
                    begin
                        stepped              = 1'b1;
                        phase_next           = phase - 2'd1;
                        last_dir_next        = DIR_REV;
                        tss_next             = '0;
                        tsf_next             = '0;
                        flags_next.energized = 1'b1;
                        if (home_left <= 10'd1)
                        begin
                            home_left_next       = '0;
                            pos_next             = '0;
                            tgt_next             = '0;
                            flags_next.running   = 1'b0;
                            flags_next.sweeping  = 1'b0;
                            flags_next.homing    = 1'b0;
                            flags_next.energized = 1'b0;
                        end
                        else
                        begin
                            home_left_next = home_left - 10'd1;
                        end
                    end
                end
                else if (flags.sweeping && flags.running)
                begin
                    if (due)
                    begin
                        if (flags.sweep_up && pos < POS_MAX)
                        begin
                            stepped              = 1'b1;
                            pos_next             = pos + POS_ONE;
                            phase_next           = phase + 2'd1;
                            last_dir_next        = DIR_FWD;
                            tsf_next             = '0;
                            flags_next.energized = 1'b1;
                        end
                        else if (!flags.sweep_up && pos != '0)
                        begin
                            stepped              = 1'b1;
                            pos_next             = pos - POS_ONE;
                            phase_next           = phase - 2'd1;
                            last_dir_next        = DIR_REV;
                            tsf_next             = '0;
                            flags_next.energized = 1'b1;
                        end
                        else
                        begin
                            flags_next.sweep_up = !flags.sweep_up;
                        end
                        tss_next = '0;
                    end
                end
                else if (flags.running && pos != tgt)
                begin
                    if (due)
                    begin
                        stepped              = 1'b1;
                        tss_next             = '0;
                        tsf_next             = '0;
                        flags_next.energized = 1'b1;
                        if (pos < tgt)
                        begin
                            pos_next      = pos + POS_ONE;
                            phase_next    = phase + 2'd1;
                            last_dir_next = DIR_FWD;
                        end
                        else
                        begin
                            pos_next      = pos - POS_ONE;
                            phase_next    = phase - 2'd1;
                            last_dir_next = DIR_REV;
                        end
                    end
                end
                else if (tsf_inc > cfg.idle_release)
                begin
                    flags_next.energized = 1'b0;
                    last_dir_next        = DIR_NONE;
                end
            end
            CMD_START:
            begin
                flags_next.running = 1'b1;
                tss_next           = '0;
            end
            CMD_STOP:
            begin
                flags_next.running   = 1'b0;
                flags_next.sweeping  = 1'b0;
                flags_next.homing    = 1'b0;
                flags_next.energized = 1'b0;
            end
            CMD_SET:
            begin
                tgt_next           = clamp_pos(amount_ext);
                flags_next.running = 1'b1;
                tss_next           = '0;
            end
            CMD_NUDGE:
            begin
                tgt_next           = clamp_pos(nudge_sum);
                flags_next.running = 1'b1;
                tss_next           = '0;
            end
            CMD_HOME:
            begin
                flags_next.homing  = 1'b1;
                home_left_next     = cfg.home_steps;
                flags_next.running = 1'b1;
                tss_next           = '0;
            end
            CMD_SWEEP:
            begin
                flags_next.sweeping = 1'b1;
                flags_next.sweep_up = 1'b1;
                flags_next.running  = 1'b1;
                tss_next            = '0;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

    always_comb
    begin
        if (flags_next.homing)
            status = ST_HOMING;
        else if (flags_next.sweeping)
            status = ST_SWEEPING;
        else if (pos_next == tgt_next)
            status = ST_LOCKED;
        else
            status = ST_MOVING;
    end

endmodule

// File: verif/valve_motion_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_motion_check
// Watches the command and result word channels of the valve stepper core,
// runs its own motor model on every accepted command word and compares each
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module valve_motion_check
    import svpc_pkg::*;
#(
    parameter int MAX_POS = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    svpc_cmd_if         cmd_mon,
    svpc_res_if         res_mon,
    output int          fault_count,
    output int          in_flight,
    output int          words_checked,
    output int          steps_seen,
    output int          releases_seen,
    output int          homes_done,
    output int          turns_seen
);

    localparam int REPORT_CAP = 100;

    // coil rows a+, a-, b+, b- for phases 3..0, phase 0 in the low nibble
    localparam logic [15:0] COIL_SEQ = {4'b1001, 4'b0101, 4'b0110, 4'b1010};

    typedef struct packed {
        logic [3:0]        coils;
        logic [7:0]        pos;
        logic [7:0]        tgt;
        logic signed [1:0] dir;
        logic              stepped;
        logic [1:0]        status;
    } valve_word_t;

    logic [9:0]        step_gap;
    logic [15:0]       release_after;
    logic [9:0]        home_len;
    logic [4:0]        gain;

    logic [1:0]        ph;
    logic [7:0]        pos;
    logic [7:0]        tgt;
    logic [9:0]        since_step;
    logic [15:0]       since_fire;
    logic [9:0]        home_left;
    logic              running;
    logic              homing;
    logic              sweeping;
    logic              sweep_up;
    logic              energized;
    logic signed [1:0] dir;

    valve_word_t       expected_words[$];
    valve_word_t       next_word;

    task automatic report_mismatch(input string field, input int got, input int want);
        fault_count++;
        if (fault_count <= REPORT_CAP)
            $display("[%0t] result word %0d: %s is %0d, expected %0d",
                     $time, words_checked, field, got, want);
    endtask

    function automatic logic [7:0] clamp_target(input int v);
        if (v < 0)
            return 8'd0;
        if (v > MAX_POS)
            return 8'(MAX_POS);
        return 8'(v);
    endfunction

    task automatic motor_step(input logic signed [1:0] d);
        ph         = ph + ((d == DIR_FWD) ? 2'd1 : 2'd3);
        energized  = 1'b1;
        dir        = d;
        since_fire = '0;
        since_step = '0;
        steps_seen++;
    endtask

    task automatic halt_motor();
        running   = 1'b0;
        homing    = 1'b0;
        sweeping  = 1'b0;
        energized = 1'b0;
    endtask

    task automatic begin_run();
        running    = 1'b1;
        since_step = '0;
    endtask

    task automatic tick_motor(output logic moved);
        logic due;
        moved = 1'b0;
        if (since_step != TSS_MAX)
            since_step++;
        if (since_fire != TSF_MAX)
            since_fire++;
        due = (since_step >= step_gap);
        if (homing)
        begin
            if (due)
            begin
                motor_step(DIR_REV);
                moved = 1'b1;
                if (home_left <= 10'd1)
                begin
                    home_left = '0;
                    pos       = '0;
                    tgt       = '0;
                    halt_motor();
                    homes_done++;
                end
                else
                    home_left--;
            end
        end
        else if (sweeping && running)
        begin
            if (due)
            begin
                if (sweep_up && int'(pos) < MAX_POS)
                begin
                    pos++;
                    motor_step(DIR_FWD);
                    moved = 1'b1;
                end
                else if (!sweep_up && pos != 8'd0)
                begin
                    pos--;
                    motor_step(DIR_REV);
                    moved = 1'b1;
                end
                else
                begin
                    // end of travel: turn around, no step on this tick
                    sweep_up   = !sweep_up;
                    since_step = '0;
                    turns_seen++;
                end
            end
        end
        else if (running && pos != tgt)
        begin
            if (due)
            begin
                if (pos < tgt)
                begin
                    pos++;
                    motor_step(DIR_FWD);
                end
                else
                begin
                    pos--;
                    motor_step(DIR_REV);
                end
                moved = 1'b1;
            end
        end
        else if (since_fire > release_after)
        begin
            if (energized)
                releases_seen++;
            energized = 1'b0;
            dir       = DIR_NONE;
        end
    endtask

    task automatic predict_word(input logic [2:0] op, input logic signed [9:0] amt,
                                output valve_word_t w);
        logic moved;
        int   base;
        int   detents;
        int   scale;
        moved = 1'b0;
        case (op)
            CMD_TICK:
                tick_motor(moved);
            CMD_START:
                begin_run();
            CMD_STOP:
                halt_motor();
            CMD_SET:
            begin
                tgt = clamp_target(amt);
                begin_run();
            end
            CMD_NUDGE:
            begin
                base    = tgt;
                detents = amt;
                scale   = gain;
                tgt     = clamp_target(base + detents * scale);
                begin_run();
            end
            CMD_HOME:
            begin
                homing    = 1'b1;
                home_left = home_len;
                begin_run();
            end
            CMD_SWEEP:
            begin
                sweeping = 1'b1;
                sweep_up = 1'b1;
                begin_run();
            end
            default: ;
        endcase
        w.coils   = energized ? COIL_SEQ[{ph, 2'b00} +: 4] : 4'b0000;
        w.pos     = pos;
        w.tgt     = tgt;
        w.dir     = dir;
        w.stepped = moved;
        if (homing)
            w.status = ST_HOMING;
        else if (sweeping)
            w.status = ST_SWEEPING;
        else if (pos == tgt)
            w.status = ST_LOCKED;
        else
            w.status = ST_MOVING;
    endtask

    task automatic compare_word(input valve_word_t want);
        if (res_mon.coil_a_plus !== want.coils[3])
            report_mismatch("coil_a_plus", res_mon.coil_a_plus, want.coils[3]);
        if (res_mon.coil_a_minus !== want.coils[2])
            report_mismatch("coil_a_minus", res_mon.coil_a_minus, want.coils[2]);
        if (res_mon.coil_b_plus !== want.coils[1])
            report_mismatch("coil_b_plus", res_mon.coil_b_plus, want.coils[1]);
        if (res_mon.coil_b_minus !== want.coils[0])
            report_mismatch("coil_b_minus", res_mon.coil_b_minus, want.coils[0]);
        if (res_mon.position !== want.pos)
            report_mismatch("position", res_mon.position, want.pos);
        if (res_mon.target_position !== want.tgt)
            report_mismatch("target_position", res_mon.target_position, want.tgt);
        if (res_mon.spin_direction !== want.dir)
            report_mismatch("spin_direction", res_mon.spin_direction, want.dir);
        if (res_mon.stepped !== want.stepped)
            report_mismatch("stepped", res_mon.stepped, want.stepped);
        if (res_mon.status !== want.status)
            report_mismatch("status", res_mon.status, want.status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gap      = STEP_INTERVAL_RST;
            release_after = IDLE_RELEASE_RST;
            home_len      = HOME_STEPS_RST;
            gain          = NUDGE_GAIN_RST;
            ph            = '0;
            pos           = '0;
            tgt           = '0;
            since_step    = '0;
            since_fire    = '0;
            home_left     = '0;
            running       = 1'b0;
            homing        = 1'b0;
            sweeping      = 1'b0;
            sweep_up      = 1'b1;
            energized     = 1'b0;
            dir           = DIR_NONE;
            expected_words.delete();
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected result word", 1, 0);
                else
                    compare_word(expected_words.pop_front());
                words_checked++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_INTERVAL: step_gap      = cfg_data[9:0];
                    REG_IDLE_RELEASE:  release_after = cfg_data;
                    REG_HOME_STEPS:    home_len      = cfg_data[9:0];
                    REG_NUDGE_GAIN:    gain          = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                predict_word(cmd_mon.command, cmd_mon.amount, next_word);
                expected_words.push_back(next_word);
            end
        end
        in_flight = expected_words.size();
    end

endmodule

// File: verif/tb_stepper_valve_position_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_valve_position_controller_core
// Drives command words into the valve stepper core under bursty traffic and a
// stalling result receiver, across several register settings; the motion
// checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_stepper_valve_position_controller_core;
    import svpc_pkg::*;

    localparam int         QUIET_LIMIT = 3000;
    localparam int         LONG_HOLD   = 64;
    localparam logic [2:0] CMD_UNUSED  = 3'd7;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    svpc_cmd_if cmd_bus();
    svpc_res_if res_bus();

    int       fault_count;
    int       in_flight;
    int       words_checked;
    int       steps_seen;
    int       releases_seen;
    int       homes_done;
    int       turns_seen;
    int       words_sent;
    int       burst_left;
    int       holds_asked;
    int       quiet_cycles = 0;
    bit       gaps_on;
    rx_mode_t rx_mode;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    stepper_valve_position_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .res       (res_bus)
    );

    valve_motion_check motion_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd_mon       (cmd_bus),
        .res_mon       (res_bus),
        .fault_count   (fault_count),
        .in_flight     (in_flight),
        .words_checked (words_checked),
        .steps_seen    (steps_seen),
        .releases_seen (releases_seen),
        .homes_done    (homes_done),
        .turns_seen    (turns_seen)
    );

    task automatic put_word(input logic [2:0] op, input logic signed [9:0] amt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    @(negedge clk);
                    cmd_bus.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
        burst_left--;
        @(negedge clk);
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= op;
        cmd_bus.amount  <= amt;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        words_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) put_word(CMD_TICK, 10'($urandom));
    endtask

    // drop valid and wait for every outstanding result word
    task automatic settle();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_regs(input logic [9:0] interval, input logic [15:0] idle_lim,
                            input logic [9:0] home_len, input logic [4:0] gain);
        write_reg(REG_STEP_INTERVAL, 16'(interval));
        write_reg(REG_IDLE_RELEASE, idle_lim);
        write_reg(REG_HOME_STEPS, 16'(home_len));
        write_reg(REG_NUDGE_GAIN, 16'(gain));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_mix(input int count, input bit with_hold);
        int                stop_at;
        int                pick;
        bit                held;
        logic signed [9:0] amt;
        stop_at = words_sent + count;
        held    = 1'b0;
        while (words_sent < stop_at)
        begin
            if (with_hold && !held && words_sent > stop_at - count / 2)
            begin
                holds_asked++;
                held = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                if ($urandom_range(0, 4) == 0)
                    amt = 10'($urandom);
                else
                    amt = 10'($urandom_range(0, 255));
                put_word(CMD_SET, amt);
                run_ticks($urandom_range(2, 24));
            end
            else if (pick < 45)
            begin
                if ($urandom_range(0, 4) == 0)
                    amt = 10'($urandom);
                else
                    amt = 10'(int'($urandom_range(0, 16)) - 8);
                put_word(CMD_NUDGE, amt);
                run_ticks($urandom_range(2, 16));
            end
            else if (pick < 55)
            begin
                put_word(CMD_HOME, 10'($urandom));
                run_ticks($urandom_range(4, 30));
            end
            else if (pick < 65)
            begin
                put_word(CMD_SWEEP, 10'($urandom));
                run_ticks($urandom_range(4, 30));
            end
            else if (pick < 75)
            begin
                put_word(($urandom_range(0, 1) != 0) ? CMD_STOP : CMD_START, 10'($urandom));
                run_ticks($urandom_range(1, 8));
            end
            else
                put_word(3'($urandom_range(0, 7)), 10'($urandom));
        end
    endtask

    // result receiver: long hold on request, otherwise per rx_mode
    initial
    begin
        int hold_left;
        int holds_taken;
        int rx_cycle;
        hold_left     = 0;
        holds_taken   = 0;
        rx_cycle      = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_taken != holds_asked)
            begin
                holds_taken++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (rx_mode == RX_RANDOM)
                res_bus.ready <= ($urandom_range(0, 99) >= 30);
            else if (rx_mode == RX_PATTERN)
                res_bus.ready <= ((rx_cycle % 7) > 2);
            else
                res_bus.ready <= 1'b1;
            rx_cycle++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (cmd_bus.valid && cmd_bus.ready) ||
            (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_STEP_INTERVAL;
        cfg_data        = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = CMD_TICK;
        cmd_bus.amount  = '0;
        words_sent      = 0;
        burst_left      = 0;
        holds_asked     = 0;
        gaps_on         = 1'b0;
        rx_mode         = RX_OPEN;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: step on every tick, instant release, zero home steps
        set_regs(10'd0, 16'd0, 10'd0, 5'd31);
        put_word(CMD_UNUSED, 10'sh155);
        put_word(CMD_TICK, 10'sh2AA);
        put_word(CMD_SET, 10'sh1FF);
        put_word(CMD_SET, 10'sh200);
        put_word(CMD_SET, 10'sd2);
        run_ticks(3);
        put_word(CMD_NUDGE, 10'sd1);
        put_word(CMD_NUDGE, 10'sh200);
        put_word(CMD_NUDGE, 10'sh1FF);
        put_word(CMD_STOP, 10'sd0);
        put_word(CMD_HOME, 10'sd0);
        run_ticks(2);
        put_word(CMD_SWEEP, 10'sd0);
        run_ticks(2);
        put_word(CMD_STOP, 10'sd0);
        put_word(CMD_START, 10'sd0);
        put_word(CMD_TICK, 10'sd0);

        // steady stream, no idling on either side
        settle();
        set_regs(10'd1, 16'd3, 10'd5, 5'd1);
        run_mix(80, 1'b0);

        // bursty sender, receiver holds off mid-phase
        settle();
        set_regs(10'd2, 16'd20, 10'd12, 5'd7);
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        run_mix(100, 1'b1);

        // full sweep: reversal at both ends of travel
        settle();
        set_regs(10'd0, 16'hFFFF, 10'd4, 5'd31);
        rx_mode = RX_PATTERN;
        put_word(CMD_STOP, 10'($urandom));
        put_word(CMD_SET, 10'sd255);
        run_ticks(256);
        put_word(CMD_SWEEP, 10'($urandom));
        run_ticks(262);
        put_word(CMD_STOP, 10'($urandom));
        put_word(CMD_TICK, 10'($urandom));

        // slowest settings
        settle();
        set_regs(10'd1023, 16'd0, 10'd1023, 5'd16);
        rx_mode = RX_RANDOM;
        run_mix(25, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            settle();
            set_regs(10'($urandom_range(0, 4)), 16'($urandom_range(0, 40)),
                     10'($urandom_range(0, 16)), 5'($urandom_range(0, 31)));
            rx_mode = rx_mode_t'(p);
            gaps_on = (p != 0);
            run_mix(70, p == 1);
        end

        settle();
        repeat (4) @(posedge clk);
        $display("covered %0d command words, %0d result words checked",
                 words_sent, words_checked);
        $display("motor steps %0d, coil releases %0d, homing runs done %0d, sweep reversals %0d",
                 steps_seen, releases_seen, homes_done, turns_seen);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
